// File: rtl/phl_pkg.sv
// ----------------------------------------------------------------------------
// phl_pkg
// Shared constants and types for the four-lane Pearson hash: lane count,
// the fixed 256-entry byte permutation and the lane control bundle.
// ----------------------------------------------------------------------------
package phl_pkg;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned HashW    = NumLanes * ByteW;
  localparam int unsigned RomDepth = 1 << ByteW;

  // control shared by all lanes for one transaction
  typedef struct packed {
    logic step;   // fold this byte (input transaction accepted)
    logic load;   // take the lane start value from the seed first
  } phl_ctrl_t;

  localparam logic [ByteW-1:0] PermRom [RomDepth] = '{
    8'd1,   8'd87,  8'd49,  8'd12,  8'd176, 8'd178, 8'd102, 8'd166,
    8'd121, 8'd193, 8'd6,   8'd84,  8'd249, 8'd230, 8'd44,  8'd163,
    8'd14,  8'd197, 8'd213, 8'd181, 8'd161, 8'd85,  8'd218, 8'd80,
    8'd64,  8'd239, 8'd24,  8'd226, 8'd236, 8'd142, 8'd38,  8'd200,
    8'd110, 8'd177, 8'd104, 8'd103, 8'd141, 8'd253, 8'd255, 8'd50,
    8'd77,  8'd101, 8'd81,  8'd18,  8'd45,  8'd96,  8'd31,  8'd222,
    8'd25,  8'd107, 8'd190, 8'd70,  8'd86,  8'd237, 8'd240, 8'd34,
    8'd72,  8'd242, 8'd20,  8'd214, 8'd244, 8'd227, 8'd149, 8'd235,
    8'd97,  8'd234, 8'd57,  8'd22,  8'd60,  8'd250, 8'd82,  8'd175,
    8'd208, 8'd5,   8'd127, 8'd199, 8'd111, 8'd62,  8'd135, 8'd248,
    8'd174, 8'd169, 8'd211, 8'd58,  8'd66,  8'd154, 8'd106, 8'd195,
    8'd245, 8'd171, 8'd17,  8'd187, 8'd182, 8'd179, 8'd0,   8'd243,
    8'd132, 8'd56,  8'd148, 8'd75,  8'd128, 8'd133, 8'd158, 8'd100,
    8'd130, 8'd126, 8'd91,  8'd13,  8'd153, 8'd246, 8'd216, 8'd219,
    8'd119, 8'd68,  8'd223, 8'd78,  8'd83,  8'd88,  8'd201, 8'd99,
    8'd122, 8'd11,  8'd92,  8'd32,  8'd136, 8'd114, 8'd52,  8'd10,
    8'd138, 8'd30,  8'd48,  8'd183, 8'd156, 8'd35,  8'd61,  8'd26,
    8'd143, 8'd74,  8'd251, 8'd94,  8'd129, 8'd162, 8'd63,  8'd152,
    8'd170, 8'd7,   8'd115, 8'd167, 8'd241, 8'd206, 8'd3,   8'd150,
    8'd55,  8'd59,  8'd151, 8'd220, 8'd90,  8'd53,  8'd23,  8'd131,
    8'd125, 8'd173, 8'd15,  8'd238, 8'd79,  8'd95,  8'd89,  8'd16,
    8'd105, 8'd137, 8'd225, 8'd224, 8'd217, 8'd160, 8'd37,  8'd123,
    8'd118, 8'd73,  8'd2,   8'd157, 8'd46,  8'd116, 8'd9,   8'd145,
    8'd134, 8'd228, 8'd207, 8'd212, 8'd202, 8'd215, 8'd69,  8'd229,
    8'd27,  8'd188, 8'd67,  8'd124, 8'd168, 8'd252, 8'd42,  8'd4,
    8'd29,  8'd108, 8'd21,  8'd247, 8'd19,  8'd205, 8'd39,  8'd203,
    8'd233, 8'd40,  8'd186, 8'd147, 8'd198, 8'd192, 8'd155, 8'd33,
    8'd164, 8'd191, 8'd98,  8'd204, 8'd165, 8'd180, 8'd117, 8'd76,
    8'd140, 8'd36,  8'd210, 8'd172, 8'd41,  8'd54,  8'd159, 8'd8,
    8'd185, 8'd232, 8'd113, 8'd196, 8'd231, 8'd47,  8'd146, 8'd120,
    8'd51,  8'd65,  8'd28,  8'd144, 8'd254, 8'd221, 8'd93,  8'd189,
    8'd194, 8'd139, 8'd112, 8'd43,  8'd71,  8'd109, 8'd184, 8'd209
  };

endpackage

// File: rtl/pearson_hash_four_lane.sv
// ----------------------------------------------------------------------------
// pearson_hash_four_lane
// Four-lane Pearson hash over a byte stream, 32-bit result per message.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle unless held off. Each lane is a 256x8
// synchronous permutation ROM whose read register holds the lane value;
// the next read address is that value XOR the incoming byte (or the seed
// byte XOR the byte when first_i is set), so the ROM read loop is what
// sets the rate of one byte per cycle. Seed byte 3 (bits 31..24) goes
// to lane 0. On a byte marked last the folded lanes pass from the lane
// registers into the output register and are returned as hash_value_o,
// lane 0 in the top byte. The result waits there, so bytes of
// the next message keep flowing while it is not yet taken; input is only
// held off when a second result is ready before the first has gone. A byte
// without first_i continues from the current lanes (zero after reset,
// else those of the previous message). No clearing pass at reset.
// ----------------------------------------------------------------------------
module pearson_hash_four_lane
  import phl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // input transactions
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic [HashW-1:0] seed_i,
  input  logic             first_i,
  input  logic             last_i,
  // result transactions
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HashW-1:0] hash_value_o
);

  phl_ctrl_t        ctrl;
  logic             fold_ready;
  logic [HashW-1:0] lanes;   // lane 0 in the top byte

  assign in_ready_o = fold_ready;
  assign ctrl.step  = in_valid_i && fold_ready;
  assign ctrl.load  = first_i;

  // lane k is fed by seed byte (NumLanes-1-k), packed the same way out
  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    phl_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .seed_byte_i (seed_i[(NumLanes-1-k)*ByteW +: ByteW]),
      .data_byte_i (data_byte_i),
      .lane_o      (lanes[(NumLanes-1-k)*ByteW +: ByteW])
    );
  end

  // result hand-off; holds the lanes while a finished hash is pending
  phl_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (ctrl.step),
    .last_i       (last_i),
    .lanes_i      (lanes),
    .fold_ready_o (fold_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

endmodule

// File: rtl/phl_lane.sv
// ----------------------------------------------------------------------------
// phl_lane
// One hash lane: a synchronous permutation ROM whose registered read data
// is the lane state. The next address is formed from that read data.
// ----------------------------------------------------------------------------
module phl_lane
  import phl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  phl_ctrl_t        ctrl_i,
  input  logic [ByteW-1:0] seed_byte_i,
  input  logic [ByteW-1:0] data_byte_i,
  output logic [ByteW-1:0] lane_o
);

  logic [ByteW-1:0] rd_q;
  logic             zero_q;   // lane still at its reset value
  logic [ByteW-1:0] cur;
  logic [ByteW-1:0] rom_addr;

  // read data fed straight back: no bubble between consecutive bytes
  assign lane_o   = zero_q ? '0 : rd_q;
  assign cur      = ctrl_i.load ? seed_byte_i : lane_o;
  assign rom_addr = cur ^ data_byte_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      rd_q <= PermRom[rom_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b1;
    end else if (ctrl_i.step) begin
      zero_q <= 1'b0;
    end
  end

endmodule

// File: rtl/phl_out.sv
// ----------------------------------------------------------------------------
// phl_out
// Result hand-off: tracks a finished hash in the lane registers and moves
// it into the output register, holding the lanes while that is blocked.
// ----------------------------------------------------------------------------
module phl_out
  import phl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             last_i,
  input  logic [HashW-1:0] lanes_i,
  output logic             fold_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HashW-1:0] hash_value_o
);

  logic             res_q, res_d;
  logic             ov_q, ov_d;
  logic [HashW-1:0] hash_q;
  logic             move;

  assign move         = res_q && (!ov_q || out_ready_i);
  assign fold_ready_o = !res_q || move;
  assign out_valid_o  = ov_q;
  assign hash_value_o = hash_q;

  always_comb begin
    res_d = res_q;
    if (move) begin
      res_d = 1'b0;
    end
    if (step_i && last_i) begin
      res_d = 1'b1;
    end
    ov_d = ov_q;
    if (move) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      res_q <= res_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      hash_q <= lanes_i;
    end
  end

endmodule

// File: rtl/phl_checker.sv
// ----------------------------------------------------------------------------
// phl_checker
// Port-level checks for the four-lane Pearson hash, bound to the top level.
// ----------------------------------------------------------------------------
module phl_checker
  import phl_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             last_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [HashW-1:0] hash_value_o
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_value_o))
    else $error("result changed while stalled");

  // with the output register empty, input is never held off
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // a last byte yields a result once it has passed the lane and output registers
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |-> ##2 out_valid_o)
    else $error("no result after last byte");

  // a fresh result only follows an accepted last byte
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_i, 2))
    else $error("result without a last byte");

endmodule

bind pearson_hash_four_lane phl_checker u_phl_checker (.*);
